>>> design/lir_pkg.sv
package lir_pkg;

    // Field and register widths
    localparam int SampleW   = 16;
    localparam int RateW     = 18;
    localparam int CfgIdxW   = 1;

    // Phase arithmetic runs wide enough to hold phase plus two source steps
    localparam int PhaseW    = RateW + 2;

    // Default saturation ratio of target to source rate
    localparam int MaxRatio  = 16;

    // Results delivered per input beat at most; further outputs are dropped
    localparam int MaxResults = 32;
    localparam int CountW     = $clog2(MaxResults + 1);

    // Signed product and weighted sum widths
    localparam int ProdW     = SampleW + RateW + 1;
    localparam int AccW      = ProdW + 1;

    // The weighted sum magnitude stays below 2**DivSteps times the target rate,
    // so the divider only has to produce DivSteps quotient bits.
    localparam int DivSteps  = SampleW + 1;
    localparam int DivCntW   = $clog2(DivSteps);

    localparam logic [RateW-1:0] RateReset = RateW'(48000);

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SOURCE_RATE = 1'b0,
        CFG_TARGET_RATE = 1'b1
    } t_cfg_idx;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_EMIT,
        ST_SKIP,
        ST_FINISH
    } t_lir_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic sum;
        logic div_init;
        logic div_step;
        logic emit;
        logic skip;
        logic finish;
    } t_lir_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic emit_cond;
        logic room;
        logic bypass;
        logic out_free;
        logic div_done;
    } t_lir_sts;

endpackage

>>> design/lir_ctrl.sv
module lir_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  lir_pkg::t_lir_sts i_sts,
    output lir_pkg::t_lir_cmd o_cmd
);
    import lir_pkg::*;

    t_lir_state r_state;
    t_lir_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (!i_sts.emit_cond) n_state = ST_FINISH;
                else if (!i_sts.room)          n_state = ST_SKIP;
                else if (i_sts.bypass)         n_state = ST_EMIT;
                else                           n_state = ST_MUL_A;
            end
            ST_MUL_A:    n_state = ST_MUL_B;
            ST_MUL_B:    n_state = ST_SUM;
            ST_SUM:      n_state = ST_DIV_INIT;
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) n_state = ST_CHECK;
            end
            ST_SKIP:     n_state = ST_CHECK;
            ST_FINISH:   n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_CHECK:    ;
            ST_MUL_A:    o_cmd.mul_a    = 1'b1;
            ST_MUL_B:    o_cmd.mul_b    = 1'b1;
            ST_SUM:      o_cmd.sum      = 1'b1;
            ST_DIV_INIT: o_cmd.div_init = 1'b1;
            ST_DIV:      o_cmd.div_step = 1'b1;
            ST_EMIT:     o_cmd.emit     = i_sts.out_free;
            ST_SKIP:     o_cmd.skip     = 1'b1;
            ST_FINISH:   o_cmd.finish   = 1'b1;
            default:     ;
        endcase
    end

endmodule

>>> design/lir_dp.sv
module lir_dp #(
    parameter int MAX_RATIO = lir_pkg::MaxRatio
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic        [lir_pkg::RateW-1:0]  i_source_rate,
    input  logic        [lir_pkg::RateW-1:0]  i_target_rate,
    input  logic signed [lir_pkg::SampleW-1:0] i_sample,
    input  logic                              i_final,
    input  lir_pkg::t_lir_cmd                 i_cmd,
    output lir_pkg::t_lir_sts                 o_sts,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic signed [lir_pkg::SampleW-1:0] o_sample,
    output logic                              o_run_end,
    output logic                              o_stream_end
);
    import lir_pkg::*;

    localparam int CapW = RateW + $clog2(MAX_RATIO + 1);

    // Recording state kept between input beats
    logic signed [SampleW-1:0]  r_left_sample;
    logic                       r_have_left;
    logic        [RateW-1:0]    r_phase;

    // Working registers for the beat in progress
    logic signed [SampleW-1:0]  r_sample;
    logic                       r_final;
    logic signed [SampleW-1:0]  r_left;
    logic        [RateW-1:0]    r_sr;
    logic        [RateW-1:0]    r_tr;
    logic        [PhaseW-1:0]   r_ph;
    logic        [CountW-1:0]   r_count;

    // Interpolation and divider registers
    logic signed [AccW-1:0]     r_acc;
    logic signed [ProdW-1:0]    r_prod;
    logic        [RateW-1:0]    r_rem;
    logic        [DivSteps-1:0] r_quo;
    logic                       r_neg;
    logic        [DivCntW-1:0]  r_div_cnt;

    // Output register
    logic                       r_out_valid;
    logic signed [SampleW-1:0]  r_out_sample;
    logic                       r_out_run_end;
    logic                       r_out_stream_end;

    logic        [RateW-1:0]    sr_sel;
    logic        [CapW-1:0]     cap;
    logic        [RateW-1:0]    tr_sel;
    logic        [PhaseW-1:0]   sr_ext;
    logic        [PhaseW-1:0]   tr_ext;
    logic        [PhaseW-1:0]   ph_a;
    logic        [PhaseW-1:0]   ph_b;
    logic                       next_cond;
    logic                       last;
    logic        [RateW-1:0]    w;
    logic signed [ProdW-1:0]    prod_a;
    logic signed [ProdW-1:0]    prod_b;
    logic        [AccW-1:0]     mag;
    logic        [RateW:0]      trial;
    logic                       ge;
    logic        [DivSteps-1:0] quo_signed;
    logic signed [SampleW-1:0]  value;

    // A phase x is inside the loop of a plain beat when x < T, and inside the
    // loop of a final beat when x + S <= 2T.
    function automatic logic in_loop(input logic fin, input logic [PhaseW-1:0] x,
                                     input logic [PhaseW-1:0] x_sr,
                                     input logic [PhaseW-1:0] t);
        logic res;
        if (fin) res = (x_sr <= {t[PhaseW-2:0], 1'b0});
        else     res = (x < t);
        return res;
    endfunction

    // Effective rates for a newly accepted beat
    assign sr_sel = (i_source_rate != '0) ? i_source_rate : i_target_rate;
    assign cap    = CapW'(sr_sel) * CapW'(MAX_RATIO);
    assign tr_sel = (CapW'(i_target_rate) > cap) ? cap[RateW-1:0] : i_target_rate;

    // Phase steps and loop conditions
    assign sr_ext    = PhaseW'(r_sr);
    assign tr_ext    = PhaseW'(r_tr);
    assign ph_a      = r_ph + sr_ext;
    assign ph_b      = ph_a + sr_ext;
    assign next_cond = in_loop(r_final, ph_a, ph_b, tr_ext);
    assign last      = !next_cond || (r_count == CountW'(MaxResults - 1));

    // Weighted products; the phase is below T whenever they are used
    assign w      = RateW'(tr_ext - r_ph);
    assign prod_a = r_left * $signed({1'b0, w});
    assign prod_b = r_sample * $signed({1'b0, r_ph[RateW-1:0]});

    // Divider step: one quotient bit per cycle
    assign mag   = r_acc[AccW-1] ? AccW'(-r_acc) : AccW'(r_acc);
    assign trial = {r_rem, r_quo[DivSteps-1]};
    assign ge    = (trial >= {1'b0, r_tr});

    // Result value, either the right sample or the signed quotient
    assign quo_signed = r_neg ? DivSteps'(-r_quo) : r_quo;
    assign value      = o_sts.bypass ? r_sample : $signed(quo_signed[SampleW-1:0]);

    // Status toward the controller
    assign o_sts.emit_cond = (r_tr != '0) && in_loop(r_final, r_ph, ph_a, tr_ext);
    assign o_sts.room      = (r_count < CountW'(MaxResults));
    assign o_sts.bypass    = (r_ph >= tr_ext);
    assign o_sts.out_free  = !r_out_valid || i_tready;
    assign o_sts.div_done  = (r_div_cnt == DivCntW'(DivSteps - 1));

    // Recording state and result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sample <= '0;
            r_have_left   <= 1'b0;
            r_phase       <= '0;
            r_count       <= '0;
        end else begin
            if (i_cmd.load) r_count <= '0;
            if (i_cmd.emit) r_count <= r_count + 1'b1;
            if (i_cmd.finish) begin
                if (r_final) begin
                    r_left_sample <= '0;
                    r_have_left   <= 1'b0;
                    r_phase       <= '0;
                end else begin
                    r_left_sample <= r_sample;
                    r_have_left   <= 1'b1;
                    r_phase       <= RateW'(r_ph - tr_ext);
                end
            end
        end
    end

    // Working registers of the current beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_final  <= i_final;
            r_sr     <= sr_sel;
            r_tr     <= tr_sel;
            r_ph     <= r_have_left ? PhaseW'(r_phase) : PhaseW'(tr_sel);
            r_left   <= r_have_left ? r_left_sample : i_sample;
        end
        if (i_cmd.emit || i_cmd.skip) r_ph <= ph_a;
    end

    // Multiply, accumulate and divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) r_acc  <= AccW'(prod_a);
        if (i_cmd.mul_b) r_prod <= prod_b;
        if (i_cmd.sum)   r_acc  <= r_acc + AccW'(r_prod);
        if (i_cmd.div_init) begin
            r_rem     <= mag[DivSteps+RateW-1:DivSteps];
            r_quo     <= mag[DivSteps-1:0];
            r_neg     <= r_acc[AccW-1];
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= ge ? RateW'(trial - {1'b0, r_tr}) : trial[RateW-1:0];
            r_quo     <= {r_quo[DivSteps-2:0], ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample     <= value;
            r_out_run_end    <= last;
            r_out_stream_end <= last && r_final;
        end
    end

    assign o_tvalid     = r_out_valid;
    assign o_sample     = r_out_sample;
    assign o_run_end    = r_out_run_end;
    assign o_stream_end = r_out_stream_end;

`ifndef SYNTH
    // The result count never passes the per-beat limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(MaxResults))
        else $error("result count above limit");

    // End of recording is always also the end of the beat's results.
    a_stream_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stream_end) |-> r_out_run_end)
        else $error("stream end without run end");

    // With no held sample the phase is back at its start.
    a_phase_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_left |-> (r_phase == '0))
        else $error("phase kept without a held sample");

    // The divider remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> (r_rem < r_tr))
        else $error("divider remainder out of range");
`endif

endmodule

>>> design/linear_interp_resampler.sv
// An interpolated result passes through the check, multiply A, multiply B, sum,
// divider init, divide and emit states; a result that repeats the right sample goes from check to emit.
// An input beat is accepted only in idle and then holds the block until all its results
// are done: each interpolated result (bit-serial divider, 17 steps), each repeated right sample,
// each output beyond 32 that is dropped, and any time the output stalls.
// Reset: synchronous, active low; clears the recording and sets both rates to 48000.
module linear_interp_resampler #(
    parameter int MAX_RATIO = lir_pkg::MaxRatio
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  lir_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic        [lir_pkg::RateW-1:0]    i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [lir_pkg::SampleW-1:0]  s_axis_tdata,  // [15:0] sample_in
    input  logic                                s_axis_tlast,  // final_sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [lir_pkg::SampleW-1:0]  m_axis_tdata,  // [15:0] sample_out
    output logic        [0:0]                   m_axis_tuser,  // [0] run_end
    output logic                                m_axis_tlast   // stream_end
);
    import lir_pkg::*;

    logic [RateW-1:0] r_source_rate;
    logic [RateW-1:0] r_target_rate;
    t_lir_cmd         cmd;
    t_lir_sts         sts;
    logic             run_end;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_rate <= RateReset;
            r_target_rate <= RateReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_RATE: r_source_rate <= i_cfg_data;
                CFG_TARGET_RATE: r_target_rate <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer
    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Phase, interpolation and output register
    lir_dp #(
        .MAX_RATIO (MAX_RATIO)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_source_rate (r_source_rate),
        .i_target_rate (r_target_rate),
        .i_sample      (s_axis_tdata),
        .i_final       (s_axis_tlast),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_sample      (m_axis_tdata),
        .o_run_end     (run_end),
        .o_stream_end  (m_axis_tlast)
    );

    assign m_axis_tuser = run_end;

endmodule
